>>> hw/rtl/lsfr_pkg.sv
// Package for the LED strip frame refresher: sizes, access codes, status codes,
// wire orders, transaction structs and the word packing function.
// No dependencies.
`default_nettype none

package lsfr_pkg;

  localparam int CHANNELS     = 4;
  localparam int MAX_LEDS     = 64;
  localparam int DEFAULT_LEDS = 16;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W     = $clog2(MAX_LEDS + 1);
  localparam int PIX_W     = 24;
  localparam int PIX_AW    = CH_W + IDX_W;
  localparam int PIX_DEPTH = CHANNELS * (2 ** IDX_W);

  localparam logic [7:0] RESET_BRIGHT = 8'd32;

  localparam logic [2:0] ACT_SET     = 3'd0;
  localparam logic [2:0] ACT_GET     = 3'd1;
  localparam logic [2:0] ACT_CLEAR   = 3'd2;
  localparam logic [2:0] ACT_CONFIG  = 3'd3;
  localparam logic [2:0] ACT_MARK    = 3'd4;
  localparam logic [2:0] ACT_QUERY   = 3'd5;
  localparam logic [2:0] ACT_SERVICE = 3'd6;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;

  localparam logic [2:0] ORD_GRB = 3'd0;
  localparam logic [2:0] ORD_RGB = 3'd1;
  localparam logic [2:0] ORD_BRG = 3'd2;
  localparam logic [2:0] ORD_BGR = 3'd3;
  localparam logic [2:0] ORD_RBG = 3'd4;
  localparam logic [2:0] ORD_GBR = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] channel;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] new_led_count;
    logic [7:0] new_brightness;
    logic [2:0] new_wire_order;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_red;
    logic [7:0]  read_green;
    logic [7:0]  read_blue;
    logic        dirty_flag;
    logic [3:0]  frame_channel;
    logic [23:0] led_word;
    logic        last;
  } out_t;

  function automatic logic [23:0] pack_word(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b, input logic [2:0] order);
    logic [23:0] w;
    unique case (order)
      ORD_RGB: w = {r, g, b};
      ORD_BRG: w = {b, r, g};
      ORD_BGR: w = {b, g, r};
      ORD_RBG: w = {r, b, g};
      ORD_GBR: w = {g, b, r};
      default: w = {g, r, b};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lsfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lsfr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/lsfr_scale.sv
// Shared brightness scaler: one color byte times brightness, divided by 255
// with truncation. Used once per color of each LED word. No dependencies.
`default_nettype none

module lsfr_scale (
  input  wire logic [7:0] color,
  input  wire logic [7:0] bright,
  output logic      [7:0] scaled
);

  logic [15:0] prod;
  logic [16:0] sum;

  // exact x/255 for 16-bit x: (x + (x >> 8) + 1) >> 8
  assign prod   = color * bright;
  assign sum    = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
  assign scaled = sum[15:8];

endmodule

`default_nettype wire

>>> hw/rtl/led_strip_frame_refresher_core.sv
// Top level of the LED strip frame refresher: access sequencer, channel registers,
// pixel store and output register. Depends on lsfr_pkg, lsfr_ram, lsfr_scale.
//
//   channel | handshake           | payload
//   in_     | in_valid / in_ready | lsfr_pkg::in_t
//   out_    | out_valid/out_ready | lsfr_pkg::out_t
//
// Access: accept, then execute; get_pixel adds a step for the RAM read.
// Service: accept, scan 1..CHANNELS channels, then per LED word fetch, scale, emit;
// the steps are set by the pixel RAM read and the one scaler shared by red, green and blue.
// Reset is synchronous, active low; pixel entries read as zero until written.
// A full output register stalls the sequencer at the step that makes a result.
`default_nettype none

module led_strip_frame_refresher_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lsfr_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lsfr_pkg::out_t      out_data
);

  import lsfr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_GET, ST_SCAN, ST_FETCH, ST_SC_R, ST_SC_G, ST_SC_B, ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  in_t                  req_r, req_nxt;
  logic                 ok_ch_r, ok_ch_nxt;
  logic [CH_W-1:0]      cur_ch_r, cur_ch_nxt;
  logic [CH_W-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic [CH_W-1:0]      ptr_r, ptr_nxt;
  logic [CHANNELS-1:0]  dirty_r, dirty_nxt;
  logic [CNT_W-1:0]     count_r [CHANNELS];
  logic [CNT_W-1:0]     count_nxt [CHANNELS];
  logic [7:0]           bright_r [CHANNELS];
  logic [7:0]           bright_nxt [CHANNELS];
  logic [2:0]           order_r [CHANNELS];
  logic [2:0]           order_nxt [CHANNELS];
  logic [PIX_DEPTH-1:0] pv_r, pv_nxt;
  logic                 pv_q_r;
  logic [7:0]           col_r_r, col_r_nxt;
  logic [7:0]           col_g_r, col_g_nxt;
  logic [7:0]           col_b_r, col_b_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic                 walking;
  logic [IDX_W-1:0]     lidx;
  logic [PIX_AW-1:0]    pix_addr;
  logic [PIX_W-1:0]     ram_rdata;
  logic [PIX_W-1:0]     pix;
  logic                 ram_we;
  logic [7:0]           sc_in;
  logic [7:0]           sc_out;
  logic [CNT_W-1:0]     count_sel;
  logic                 idx_ok;
  logic                 is_last;
  logic                 slot_free;
  logic                 load;
  logic                 cfg_ok;
  out_t                 res;
  logic [CH_W-1:0]      cur_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign walking  = (state_r == ST_FETCH) || (state_r == ST_SC_R) || (state_r == ST_SC_G) ||
                    (state_r == ST_SC_B) || (state_r == ST_EMIT);
  assign lidx     = walking ? k_r : req_r.pixel_index[IDX_W-1:0];
  assign pix_addr = {cur_ch_r, lidx};
  assign pix      = pv_q_r ? ram_rdata : '0;

  assign count_sel = count_r[cur_ch_r];
  assign idx_ok    = ok_ch_r && (req_r.pixel_index < 8'(count_sel));
  assign is_last   = (CNT_W'(k_r) + CNT_W'(1)) == count_sel;
  assign slot_free = !out_valid_r || out_ready;
  assign cur_inc   = (32'(cur_ch_r) == CHANNELS - 1) ? '0 : cur_ch_r + CH_W'(1);
  assign cfg_ok    = ok_ch_r && (req_r.new_led_count != 8'd0) &&
                     (req_r.new_led_count <= 8'(MAX_LEDS)) && (req_r.new_wire_order <= ORD_GBR);

  always_comb begin
    unique case (state_r)
      ST_SC_R: sc_in = pix[23:16];
      ST_SC_G: sc_in = pix[15:8];
      default: sc_in = pix[7:0];
    endcase
  end

  lsfr_scale u_scale (
    .color  (sc_in),
    .bright (bright_r[cur_ch_r]),
    .scaled (sc_out)
  );

  lsfr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIX_DEPTH)
  ) u_pix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pix_addr),
    .wdata ({req_r.red, req_r.green, req_r.blue}),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    ok_ch_nxt     = ok_ch_r;
    cur_ch_nxt    = cur_ch_r;
    scan_cnt_nxt  = scan_cnt_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    dirty_nxt     = dirty_r;
    count_nxt     = count_r;
    bright_nxt    = bright_r;
    order_nxt     = order_r;
    pv_nxt        = pv_r;
    col_r_nxt     = col_r_r;
    col_g_nxt     = col_g_r;
    col_b_nxt     = col_b_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    load          = 1'b0;
    res           = '0;
    res.last      = 1'b1;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          ok_ch_nxt    = in_data.channel < 8'(CHANNELS);
          scan_cnt_nxt = '0;
          k_nxt        = '0;
          if (in_data.action == ACT_SERVICE) begin
            cur_ch_nxt = ptr_r;
            state_nxt  = ST_SCAN;
          end else begin
            cur_ch_nxt = (in_data.channel < 8'(CHANNELS)) ? in_data.channel[CH_W-1:0] : '0;
            state_nxt  = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (req_r.action == ACT_GET) begin
          state_nxt = ST_GET;
        end else if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
          unique case (req_r.action)
            ACT_SET: begin
              if (idx_ok) begin
                ram_we                = 1'b1;
                pv_nxt[pix_addr]      = 1'b1;
                dirty_nxt[cur_ch_r]   = 1'b1;
              end else begin
                res.status = STAT_RANGE;
              end
            end
            ACT_CLEAR: begin
              if (ok_ch_r) begin
                for (int i = 0; i < PIX_DEPTH; i++) begin
                  if ((i >> IDX_W) == int'(cur_ch_r)) begin
                    pv_nxt[i] = 1'b0;
                  end
                end
                dirty_nxt[cur_ch_r] = 1'b1;
              end else begin
                res.status = STAT_RANGE;
              end
            end
            ACT_CONFIG: begin
              if (cfg_ok) begin
                count_nxt[cur_ch_r]  = CNT_W'(req_r.new_led_count);
                bright_nxt[cur_ch_r] = req_r.new_brightness;
                order_nxt[cur_ch_r]  = req_r.new_wire_order;
                dirty_nxt[cur_ch_r]  = 1'b1;
              end else begin
                res.status = STAT_INVALID;
              end
            end
            ACT_MARK: begin
              if (ok_ch_r) begin
                dirty_nxt[cur_ch_r] = 1'b1;
              end
            end
            ACT_QUERY: begin
              res.dirty_flag = ok_ch_r && dirty_r[cur_ch_r];
            end
            default: begin
              res.status = STAT_INVALID;
            end
          endcase
        end
      end
      ST_GET: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
          if (idx_ok) begin
            res.read_red   = pix[23:16];
            res.read_green = pix[15:8];
            res.read_blue  = pix[7:0];
          end else begin
            res.status = STAT_RANGE;
          end
        end
      end
      ST_SCAN: begin
        if (dirty_r[cur_ch_r]) begin
          k_nxt     = '0;
          state_nxt = ST_FETCH;
        end else if (32'(scan_cnt_r) == CHANNELS - 1) begin
          state_nxt = ST_IDLE;
        end else begin
          cur_ch_nxt   = cur_inc;
          scan_cnt_nxt = scan_cnt_r + CH_W'(1);
        end
      end
      ST_FETCH: begin
        state_nxt = ST_SC_R;
      end
      ST_SC_R: begin
        col_r_nxt = sc_out;
        state_nxt = ST_SC_G;
      end
      ST_SC_G: begin
        col_g_nxt = sc_out;
        state_nxt = ST_SC_B;
      end
      ST_SC_B: begin
        col_b_nxt = sc_out;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          load              = 1'b1;
          res.frame_channel = 4'(cur_ch_r);
          res.led_word      = pack_word(col_r_r, col_g_r, col_b_r, order_r[cur_ch_r]);
          res.last          = is_last;
          if (is_last) begin
            dirty_nxt[cur_ch_r] = 1'b0;
            ptr_nxt             = cur_inc;
            state_nxt           = ST_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      dirty_r     <= '1;
      pv_r        <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        count_r[c]  <= CNT_W'(DEFAULT_LEDS);
        bright_r[c] <= RESET_BRIGHT;
        order_r[c]  <= ORD_GRB;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      dirty_r     <= dirty_nxt;
      pv_r        <= pv_nxt;
      count_r     <= count_nxt;
      bright_r    <= bright_nxt;
      order_r     <= order_nxt;
    end
    req_r      <= req_nxt;
    ok_ch_r    <= ok_ch_nxt;
    cur_ch_r   <= cur_ch_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    k_r        <= k_nxt;
    col_r_r    <= col_r_nxt;
    col_g_r    <= col_g_nxt;
    col_b_r    <= col_b_nxt;
    out_data_r <= out_data_nxt;
    pv_q_r     <= pv_r[pix_addr];
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while previous transaction still in progress");

  a_walk_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> dirty_r[cur_ch_r])
    else $error("emitting words for a channel that is not dirty");

  a_walk_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    walking |-> (CNT_W'(k_r) < count_sel))
    else $error("LED index walked past channel LED count");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && slot_free && is_last) |=> !dirty_r[$past(cur_ch_r)])
    else $error("dirty flag not cleared after final word");

endmodule

`default_nettype wire

>>> sim/led_strip_frame_refresher_core_test.sv
// Testbench for led_strip_frame_refresher_core: random and directed accesses with a
// frame store predictor in a scoreboard class. Depends on lsfr_pkg and the core RTL.
`default_nettype none

module led_strip_frame_refresher_core_test;
  import lsfr_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int unsigned ITEMS = 450;
  localparam int unsigned LONG_GAP = 40;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned LIMIT =
    (ITEMS + 50) * (MAX_LEDS * (6 + LONG_GAP) + LONG_GAP + CHANNELS + 10) * 3;

  class frame_scoreboard;
    out_t       pending_words[$];
    bit [7:0]   red_mem[CHANNELS * MAX_LEDS];
    bit [7:0]   green_mem[CHANNELS * MAX_LEDS];
    bit [7:0]   blue_mem[CHANNELS * MAX_LEDS];
    bit         dirty[CHANNELS];
    bit [7:0]   led_cnt[CHANNELS];
    bit [7:0]   bright[CHANNELS];
    bit [2:0]   order[CHANNELS];
    int         rr_ptr;
    int         mismatches;

    function new();
      for (int k = 0; k < CHANNELS * MAX_LEDS; k++) begin
        red_mem[k] = 0;
        green_mem[k] = 0;
        blue_mem[k] = 0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        dirty[c] = 1;
        led_cnt[c] = DEFAULT_LEDS;
        bright[c] = RESET_BRIGHT;
        order[c] = ORD_GRB;
      end
      rr_ptr = 0;
      mismatches = 0;
    endfunction

    function int lit_count(int ch);
      if (ch >= CHANNELS) return 0;
      return (led_cnt[ch] > MAX_LEDS) ? MAX_LEDS : led_cnt[ch];
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    function bit [7:0] scale_color(bit [7:0] c, bit [7:0] b);
      bit [15:0] prod;
      prod = c * b;
      return 8'(prod / 16'd255);
    endfunction

    function bit [23:0] order_word(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [2:0] ord);
      case (ord)
        ORD_RGB: return {r, g, b};
        ORD_BRG: return {b, r, g};
        ORD_BGR: return {b, g, r};
        ORD_RBG: return {r, b, g};
        ORD_GBR: return {g, b, r};
        default: return {g, r, b};
      endcase
    endfunction

    function void expect_word(logic [1:0] st, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic dflag, logic [3:0] ch, logic [23:0] word, logic fin);
      out_t e;
      e.status = st;
      e.read_red = r;
      e.read_green = g;
      e.read_blue = b;
      e.dirty_flag = dflag;
      e.frame_channel = ch;
      e.led_word = word;
      e.last = fin;
      pending_words.push_back(e);
    endfunction

    function void note_access(in_t a);
      bit ok_ch;
      int base;
      int p;
      int pick;
      int n;
      bit found;
      bit [7:0] br;
      ok_ch = a.channel < CHANNELS;
      base = ok_ch ? a.channel * MAX_LEDS : 0;
      p = base + a.pixel_index;
      case (a.action)
        ACT_SET: begin
          if (!ok_ch || a.pixel_index >= lit_count(a.channel)) begin
            expect_word(STAT_RANGE, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            red_mem[p] = a.red;
            green_mem[p] = a.green;
            blue_mem[p] = a.blue;
            dirty[a.channel] = 1;
            expect_word(STAT_OK, 0, 0, 0, 0, 0, 0, 1);
          end
        end
        ACT_GET: begin
          if (!ok_ch || a.pixel_index >= lit_count(a.channel))
            expect_word(STAT_RANGE, 0, 0, 0, 0, 0, 0, 1);
          else
            expect_word(STAT_OK, red_mem[p], green_mem[p], blue_mem[p], 0, 0, 0, 1);
        end
        ACT_CLEAR: begin
          if (!ok_ch) begin
            expect_word(STAT_RANGE, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            for (int k = 0; k < MAX_LEDS; k++) begin
              red_mem[base + k] = 0;
              green_mem[base + k] = 0;
              blue_mem[base + k] = 0;
            end
            dirty[a.channel] = 1;
            expect_word(STAT_OK, 0, 0, 0, 0, 0, 0, 1);
          end
        end
        ACT_CONFIG: begin
          if (!ok_ch || a.new_led_count == 0 || a.new_led_count > MAX_LEDS ||
              a.new_wire_order > ORD_GBR) begin
            expect_word(STAT_INVALID, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            led_cnt[a.channel] = a.new_led_count;
            bright[a.channel] = a.new_brightness;
            order[a.channel] = a.new_wire_order;
            dirty[a.channel] = 1;
            expect_word(STAT_OK, 0, 0, 0, 0, 0, 0, 1);
          end
        end
        ACT_MARK: begin
          if (ok_ch) dirty[a.channel] = 1;
          expect_word(STAT_OK, 0, 0, 0, 0, 0, 0, 1);
        end
        ACT_QUERY: begin
          expect_word(STAT_OK, 0, 0, 0, ok_ch && dirty[a.channel], 0, 0, 1);
        end
        ACT_SERVICE: begin
          found = 0;
          pick = 0;
          for (int off = 0; off < CHANNELS; off++) begin
            if (!found && dirty[(rr_ptr + off) % CHANNELS]) begin
              found = 1;
              pick = (rr_ptr + off) % CHANNELS;
            end
          end
          if (found) begin
            n = lit_count(pick);
            br = bright[pick];
            for (int k = 0; k < n; k++) begin
              p = pick * MAX_LEDS + k;
              expect_word(STAT_OK, 0, 0, 0, 0, 4'(pick),
                          order_word(scale_color(red_mem[p], br),
                                     scale_color(green_mem[p], br),
                                     scale_color(blue_mem[p], br), order[pick]),
                          k == n - 1);
            end
            dirty[pick] = 0;
            rr_ptr = (pick + 1) % CHANNELS;
          end
        end
        default: expect_word(STAT_INVALID, 0, 0, 0, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_word(out_t got);
      out_t e;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d rgb=%h/%h/%h dflag=%0d ch=%0d word=%h last=%0d",
                   got.status, got.read_red, got.read_green, got.read_blue,
                   got.dirty_flag, got.frame_channel, got.led_word, got.last);
        return;
      end
      e = pending_words.pop_front();
      if (got.status !== e.status || got.read_red !== e.read_red ||
          got.read_green !== e.read_green || got.read_blue !== e.read_blue ||
          got.dirty_flag !== e.dirty_flag || got.frame_channel !== e.frame_channel ||
          got.led_word !== e.led_word || got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch expected: st=%0d rgb=%h/%h/%h dflag=%0d ch=%0d word=%h last=%0d",
                   e.status, e.read_red, e.read_green, e.read_blue,
                   e.dirty_flag, e.frame_channel, e.led_word, e.last);
          $display("mismatch actual:   st=%0d rgb=%h/%h/%h dflag=%0d ch=%0d word=%h last=%0d",
                   got.status, got.read_red, got.read_green, got.read_blue,
                   got.dirty_flag, got.frame_channel, got.led_word, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  frame_scoreboard sb;
  bit in_calm;
  bit out_calm;
  int unsigned cycles;

  led_strip_frame_refresher_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  function automatic int pick_gap(inout bit calm);
    int r;
    if ($urandom_range(0, 99) < 4) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, LONG_GAP);
  endfunction

  function automatic in_t access(logic [2:0] act, logic [7:0] ch, logic [7:0] idx,
                                 logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [7:0] cnt, logic [7:0] br, logic [2:0] ord);
    in_t a;
    a.action = act;
    a.channel = ch;
    a.pixel_index = idx;
    a.red = r;
    a.green = g;
    a.blue = b;
    a.new_led_count = cnt;
    a.new_brightness = br;
    a.new_wire_order = ord;
    return a;
  endfunction

  function automatic in_t random_access();
    in_t a;
    bit [63:0] raw;
    int r;
    int n;
    raw = {$urandom, $urandom};
    a = in_t'(raw[$bits(in_t)-1:0]);
    r = $urandom_range(0, 99);
    if (r >= 88) return a;
    if (r < 28) a.action = ACT_SET;
    else if (r < 42) a.action = ACT_GET;
    else if (r < 56) a.action = ACT_SERVICE;
    else if (r < 68) a.action = ACT_CONFIG;
    else if (r < 72) a.action = ACT_CLEAR;
    else if (r < 80) a.action = ACT_MARK;
    else a.action = ACT_QUERY;
    if ($urandom_range(0, 99) < 92) a.channel = 8'($urandom_range(0, CHANNELS - 1));
    n = sb.lit_count(a.channel);
    if (n > 0 && $urandom_range(0, 99) < 90) a.pixel_index = 8'($urandom_range(0, n - 1));
    r = $urandom_range(0, 99);
    if (r < 80) a.new_led_count = 8'($urandom_range(1, 12));
    else if (r < 88) a.new_led_count = 8'(MAX_LEDS);
    r = $urandom_range(0, 99);
    if (r < 20) a.new_brightness = 8'hFF;
    else if (r < 30) a.new_brightness = 8'h00;
    if ($urandom_range(0, 99) < 90) a.new_wire_order = 3'($urandom_range(ORD_GRB, ORD_GBR));
    return a;
  endfunction

  task automatic send_access(in_t a);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_data = a;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_access(a);
    @(negedge clk);
  endtask

  task automatic hold_for_drain();
    in_valid = 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int hold;
    hold = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 0;
        hold--;
      end else begin
        out_ready = 1;
        hold = pick_gap(out_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    in_calm = 0;
    out_calm = 0;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (2) @(negedge clk);
    rst_n = 1;

    send_access(access(ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_GET, 3, 15, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_GET, 0, 16, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_SET, 0, 0, 8'hFF, 8'h00, 8'h80, 0, 0, 0));
    send_access(access(ACT_SET, 8'hFF, 0, 1, 2, 3, 0, 0, 0));
    send_access(access(ACT_SET, CHANNELS, 0, 1, 2, 3, 0, 0, 0));
    send_access(access(ACT_CONFIG, 0, 0, 0, 0, 0, MAX_LEDS, 8'hFF, ORD_RGB));
    send_access(access(ACT_CONFIG, 1, 0, 0, 0, 0, 0, 8'h40, ORD_GRB));
    send_access(access(ACT_CONFIG, 1, 0, 0, 0, 0, MAX_LEDS + 1, 8'h40, ORD_GRB));
    send_access(access(ACT_CONFIG, 2, 0, 0, 0, 0, 8'hFF, 8'h00, 3'd7));
    send_access(access(ACT_CONFIG, 3, 0, 0, 0, 0, 1, 8'h00, ORD_GBR));
    send_access(access(ACT_CONFIG, 5, 0, 0, 0, 0, 8, 8'h40, ORD_BRG));
    send_access(access(ACT_SET, 0, MAX_LEDS - 1, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0));
    send_access(access(ACT_GET, 0, MAX_LEDS - 1, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_GET, 0, 8'hFF, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_MARK, 200, 0, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_QUERY, 9, 0, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'h7));
    repeat (5) send_access(access(ACT_SERVICE, 0, 0, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_QUERY, 1, 0, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_CLEAR, 2, 0, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_CLEAR, 17, 0, 0, 0, 0, 0, 0, 0));
    send_access(access(ACT_CONFIG, 1, 0, 0, 0, 0, 3, 8'h80, ORD_BGR));
    send_access(access(ACT_SET, 1, 2, 8'h12, 8'hC4, 8'h7F, 0, 0, 0));
    send_access(access(ACT_SERVICE, 0, 0, 0, 0, 0, 0, 0, 0));
    hold_for_drain();

    for (int i = 0; i < ITEMS; i++) begin
      if (i == ITEMS / 2) hold_for_drain();
      send_access(random_access());
    end

    hold_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
